// ===== design/ps2_mouse_packet_tracker_core_macros.svh =====
// Assertion macros shared by the PS/2 mouse packet tracker RTL.
// Each macro expands to one labelled concurrent assertion clocked on the given clock.
`ifndef PS2_MOUSE_PACKET_TRACKER_CORE_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_CORE_MACROS_SVH

// Checked only while out of reset (reset is active low).
`define PMT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("%m: assertion failed");

// Checked at every edge, reset included.
`define PMT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// ===== design/ps2mpt_pkg.sv =====
// Package for the PS/2 mouse packet tracker: field widths, flag-byte bit positions,
// reset constants, register indexes, the result word type and the clamp helpers.
// No dependencies.
`default_nettype none

package ps2mpt_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned EXT_W  = 13;
    localparam int unsigned POS_W  = 12;
    localparam int unsigned BTN_W  = 3;
    localparam int unsigned MOVE_W = BYTE_W + 1;
    localparam int unsigned SUM_W  = POS_W + 2;
    localparam int unsigned IDX_W  = 2;

    // Flag byte layout
    localparam int unsigned FIRST_MARK_BIT = 3;
    localparam int unsigned X_SIGN_BIT     = 4;
    localparam int unsigned Y_SIGN_BIT     = 5;
    localparam logic [BYTE_W-1:0] OVERFLOW_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] BUTTON_MASK   = 8'h07;

    localparam logic [EXT_W-1:0] WIDTH_RESET  = 13'd800;
    localparam logic [EXT_W-1:0] HEIGHT_RESET = 13'd600;
    localparam logic [EXT_W-1:0] EXT_FULL     = 13'd4096;
    localparam logic [POS_W-1:0] POS_X_RESET  = 12'd400;
    localparam logic [POS_W-1:0] POS_Y_RESET  = 12'd300;
    localparam logic [POS_W-1:0] POS_MAX      = 12'd4095;

    typedef enum logic [IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [POS_W-1:0] cursor_x;
        logic [POS_W-1:0] cursor_y;
        logic [BTN_W-1:0] button_bits;
        logic             clickable;
    } cursor_t;

    // Largest legal position for a screen extent; zero acts as one.
    function automatic logic [POS_W-1:0] limit_of(input logic [EXT_W-1:0] ext);
        logic [EXT_W-1:0] lim;
        lim = ext - EXT_W'(1);
        if (ext == '0) begin
            return '0;
        end else if (ext > EXT_FULL) begin
            return POS_MAX;
        end else begin
            return lim[POS_W-1:0];
        end
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [SUM_W-1:0] v,
                                                   input logic [POS_W-1:0] lim);
        if (v < 0) begin
            return '0;
        end else if (v > $signed({2'b00, lim})) begin
            return lim;
        end else begin
            return v[POS_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/ps2mpt_tracker.sv =====
// Packet assembly and cursor update for the PS/2 mouse packet tracker.
// Depends on ps2mpt_pkg. Produces at most one result word per accepted byte, same cycle.
`default_nettype none

module ps2mpt_tracker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           byte_take,
    input  wire logic [ps2mpt_pkg::BYTE_W-1:0]  mouse_byte,
    input  wire logic [ps2mpt_pkg::EXT_W-1:0]   screen_width,
    input  wire logic [ps2mpt_pkg::EXT_W-1:0]   screen_height,
    output logic                                result_valid,
    output ps2mpt_pkg::cursor_t                 result
);
    import ps2mpt_pkg::*;

    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_XMOVE = 2'd1,
        PH_YMOVE = 2'd2
    } phase_t;

    phase_t              phase_reg,   phase_next;
    logic [BYTE_W-1:0]   flag_reg,    flag_next;
    logic [BYTE_W-1:0]   move_x_reg,  move_x_next;
    logic [POS_W-1:0]    pos_x_reg,   pos_x_next;
    logic [POS_W-1:0]    pos_y_reg,   pos_y_next;
    logic [BTN_W-1:0]    buttons_reg, buttons_next;
    logic                kind_reg,    kind_next;

    logic [MOVE_W-1:0]       dx;
    logic [MOVE_W-1:0]       dy;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;

    // Sign flag from the flag byte is the ninth bit of each move.
    assign dx    = {flag_reg[X_SIGN_BIT], move_x_reg};
    assign dy    = {flag_reg[Y_SIGN_BIT], mouse_byte};
    assign sum_x = $signed({2'b00, pos_x_reg}) + $signed({{(SUM_W-MOVE_W){dx[MOVE_W-1]}}, dx});
    assign sum_y = $signed({2'b00, pos_y_reg}) - $signed({{(SUM_W-MOVE_W){dy[MOVE_W-1]}}, dy});

    always_comb begin
        phase_next   = phase_reg;
        flag_next    = flag_reg;
        move_x_next  = move_x_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        buttons_next = buttons_reg;
        kind_next    = kind_reg;
        result_valid = 1'b0;
        if (byte_take) begin
            case (phase_reg)
                PH_XMOVE: begin
                    move_x_next = mouse_byte;
                    phase_next  = PH_YMOVE;
                end
                PH_YMOVE: begin
                    phase_next = PH_FLAG;
                    // drop the packet on either overflow flag
                    if ((flag_reg & OVERFLOW_MASK) == '0) begin
                        buttons_next = flag_reg[BTN_W-1:0] & BUTTON_MASK[BTN_W-1:0];
                        kind_next    = flag_reg[0];
                        pos_x_next   = clamp_pos(sum_x, limit_of(screen_width));
                        pos_y_next   = clamp_pos(sum_y, limit_of(screen_height));
                        result_valid = 1'b1;
                    end
                end
                default: begin
                    // resynchronise: only a byte with the mark bit opens a packet
                    if (mouse_byte[FIRST_MARK_BIT]) begin
                        flag_next  = mouse_byte;
                        phase_next = PH_XMOVE;
                    end else begin
                        phase_next = PH_FLAG;
                    end
                end
            endcase
        end
    end

    assign result.cursor_x    = pos_x_next;
    assign result.cursor_y    = pos_y_next;
    assign result.button_bits = buttons_next;
    assign result.clickable   = kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FLAG;
            flag_reg    <= '0;
            move_x_reg  <= '0;
            pos_x_reg   <= POS_X_RESET;
            pos_y_reg   <= POS_Y_RESET;
            buttons_reg <= '0;
            kind_reg    <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            flag_reg    <= flag_next;
            move_x_reg  <= move_x_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            buttons_reg <= buttons_next;
            kind_reg    <= kind_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/ps2_mouse_packet_tracker_core.sv =====
// PS/2 mouse packet tracker, top level: configuration registers, tracker and output buffer.
// Depends on ps2mpt_pkg, ps2mpt_tracker and ps2_mouse_packet_tracker_core_macros.svh.
//
// Takes one mouse byte per word on the s_ channel, every cycle while s_ready is high, and gives
// one cursor word on the m_ channel for each complete three-byte packet without overflow. The
// cursor update (one add and clamp per axis) completes in the cycle the third byte is taken,
// and the word is registered in the output stage before it appears on m_. Results pass through
// a two-deep output stage (output register plus skid register), so s_ready drops only while
// both hold words. screen_width (index 0) and screen_height (index 1) reset to 800 and 600;
// write them only while no packet is in flight. The position resets to 400, 300.
`default_nettype none

module ps2_mouse_packet_tracker_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [ps2mpt_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [ps2mpt_pkg::EXT_W-1:0]      cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [ps2mpt_pkg::BYTE_W-1:0]     s_mouse_byte,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [ps2mpt_pkg::POS_W-1:0]           m_cursor_x,
    output logic [ps2mpt_pkg::POS_W-1:0]           m_cursor_y,
    output logic [ps2mpt_pkg::BTN_W-1:0]           m_button_bits,
    output logic                                   m_clickable
);
    import ps2mpt_pkg::*;

    `include "ps2_mouse_packet_tracker_core_macros.svh"

    logic [EXT_W-1:0] width_reg;
    logic [EXT_W-1:0] height_reg;

    logic    in_take;
    logic    res_valid;
    cursor_t res_word;

    cursor_t out_reg;
    logic    out_valid_reg;
    cursor_t skid_reg;
    logic    skid_valid_reg;

    assign s_ready = !skid_valid_reg;
    assign in_take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_SCREEN_WIDTH) begin
                width_reg <= cfg_wdata;
            end
            if (cfg_index == REG_SCREEN_HEIGHT) begin
                height_reg <= cfg_wdata;
            end
        end
    end

    ps2mpt_tracker u_tracker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .byte_take     (in_take),
        .mouse_byte    (s_mouse_byte),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .result_valid  (res_valid),
        .result        (res_word)
    );

    // A new word can only arrive while the skid register is empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (res_valid) begin
                out_reg <= res_word;
            end
        end else if (res_valid) begin
            skid_reg <= res_word;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_cursor_x    = out_reg.cursor_x;
    assign m_cursor_y    = out_reg.cursor_y;
    assign m_button_bits = out_reg.button_bits;
    assign m_clickable   = out_reg.clickable;

    `PMT_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg)
    `PMT_ASSERT(a_no_push_when_full, aclk, aresetn, res_valid |-> !skid_valid_reg)
    `PMT_ASSERT(a_skid_held_on_stall, aclk, aresetn,
                (skid_valid_reg && !m_ready) |=> (skid_valid_reg && out_valid_reg))
    `PMT_ASSERT(a_click_follows_left, aclk, aresetn,
                m_valid |-> (m_clickable == m_button_bits[0]))
    `PMT_ASSERT_ALWAYS(a_empty_after_reset, aclk,
                       !aresetn |=> (!out_valid_reg && !skid_valid_reg))

endmodule

`default_nettype wire

// ===== test/tb_ps2_mouse_packet_tracker_core.sv =====
// Self-checking testbench for ps2_mouse_packet_tracker_core: feeds mouse bytes, predicts
// cursor words packet by packet and checks them on the m_ channel.
// Depends on ps2mpt_pkg and the core RTL.
`default_nettype none

module tb_ps2_mouse_packet_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2mpt_pkg::*;

    localparam int RUN_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [1:0] {
        WAIT_FLAGS = 2'd0,
        WAIT_DX    = 2'd1,
        WAIT_DY    = 2'd2
    } pkt_phase_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = REG_SCREEN_WIDTH;
    logic [EXT_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [BYTE_W-1:0] s_mouse_byte = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [POS_W-1:0] m_cursor_x;
    logic [POS_W-1:0] m_cursor_y;
    logic [BTN_W-1:0] m_button_bits;
    logic m_clickable;

    // Stimulus and expectation stores
    logic [BYTE_W-1:0] pending_bytes[$];
    cursor_t cursor_due[$];
    pkt_phase_t gen_phase = WAIT_FLAGS;

    // Tracker state as the block should hold it
    pkt_phase_t pkt_phase = WAIT_FLAGS;
    logic [BYTE_W-1:0] flags_held = '0;
    logic [BYTE_W-1:0] dx_byte = '0;
    logic [POS_W-1:0] track_x = POS_X_RESET;
    logic [POS_W-1:0] track_y = POS_Y_RESET;
    logic [BTN_W-1:0] btn_state = '0;
    logic click_state = 1'b0;
    logic [EXT_W-1:0] scr_w = WIDTH_RESET;
    logic [EXT_W-1:0] scr_h = HEIGHT_RESET;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    int unsigned rx_left = 0;
    int unsigned hold_left = 0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;

    ps2_mouse_packet_tracker_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mouse_byte  (s_mouse_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cursor_x    (m_cursor_x),
        .m_cursor_y    (m_cursor_y),
        .m_button_bits (m_button_bits),
        .m_clickable   (m_clickable)
    );

    always #5 aclk = ~aclk;

    // Zero extent acts as one; anything past 4096 saturates at the 12-bit maximum.
    function automatic logic [POS_W-1:0] axis_clamp(input int v, input logic [EXT_W-1:0] ext);
        int lim;
        lim = (ext == '0) ? 0 : int'(ext) - 1;
        if (lim > int'(POS_MAX))
            lim = int'(POS_MAX);
        if (v < 0)
            v = 0;
        if (v > lim)
            v = lim;
        return POS_W'(v);
    endfunction

    function automatic pkt_phase_t phase_after(input pkt_phase_t ph, input logic [BYTE_W-1:0] b);
        case (ph)
            WAIT_DX: return WAIT_DY;
            WAIT_DY: return WAIT_FLAGS;
            default: return b[FIRST_MARK_BIT] ? WAIT_DX : WAIT_FLAGS;
        endcase
    endfunction

    // Advance the tracker by one accepted byte and queue the cursor word it produces.
    function void track_byte(input logic [BYTE_W-1:0] b);
        int dx;
        int dy;
        cursor_t due;
        case (pkt_phase)
            WAIT_DX: begin
                dx_byte = b;
                pkt_phase = WAIT_DY;
            end
            WAIT_DY: begin
                pkt_phase = WAIT_FLAGS;
                if ((flags_held & OVERFLOW_MASK) == '0) begin
                    dx = int'(dx_byte) - (flags_held[X_SIGN_BIT] ? 256 : 0);
                    dy = int'(b) - (flags_held[Y_SIGN_BIT] ? 256 : 0);
                    btn_state = flags_held[BTN_W-1:0];
                    track_x = axis_clamp(int'(track_x) + dx, scr_w);
                    track_y = axis_clamp(int'(track_y) - dy, scr_h);
                    click_state = btn_state[0];
                    due.cursor_x = track_x;
                    due.cursor_y = track_y;
                    due.button_bits = btn_state;
                    due.clickable = click_state;
                    cursor_due.push_back(due);
                end
            end
            default: begin
                if (b[FIRST_MARK_BIT]) begin
                    flags_held = b;
                    pkt_phase = WAIT_DX;
                end else begin
                    pkt_phase = WAIT_FLAGS;
                end
            end
        endcase
    endfunction

    function void queue_byte(input logic [BYTE_W-1:0] b);
        pending_bytes.push_back(b);
        gen_phase = phase_after(gen_phase, b);
    endfunction

    function void queue_packet(input logic [BYTE_W-1:0] flags, input logic [BYTE_W-1:0] xb,
                               input logic [BYTE_W-1:0] yb);
        queue_byte(flags);
        queue_byte(xb);
        queue_byte(yb);
    endfunction

    // Mostly aligned packets drifting towards one corner, plus loose bytes and torn packets.
    task automatic queue_mix(input int count);
        int made;
        bit rise_x;
        bit rise_y;
        logic [BYTE_W-1:0] flags;
        made = 0;
        rise_x = 1'($urandom_range(1));
        rise_y = 1'($urandom_range(1));
        while (made < count) begin
            if ($urandom_range(99) < 12) begin
                queue_byte(BYTE_W'($urandom_range(255)));
                made++;
            end else begin
                if ($urandom_range(1) == 1) begin
                    while (gen_phase != WAIT_FLAGS) begin
                        queue_byte(BYTE_W'($urandom_range(255)));
                        made++;
                    end
                end
                flags = BYTE_W'($urandom_range(255));
                flags[FIRST_MARK_BIT] = 1'b1;
                if ($urandom_range(99) < 85)
                    flags = flags & ~OVERFLOW_MASK;
                if ($urandom_range(99) < 60) begin
                    flags[X_SIGN_BIT] = !rise_x;
                    flags[Y_SIGN_BIT] = rise_y;
                end
                queue_packet(flags, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
                made += 3;
                if ($urandom_range(99) < 6)
                    rise_x = !rise_x;
                if ($urandom_range(99) < 6)
                    rise_y = !rise_y;
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_valid || cursor_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [EXT_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_SCREEN_WIDTH)
            scr_w = val;
        else
            scr_h = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_setting(input logic [EXT_W-1:0] w, input logic [EXT_W-1:0] h,
                               input int count, input bit hold_off);
        wait_idle();
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        if (hold_off)
            hold_req <= hold_req + 1;
        queue_mix(count);
        // Close any torn packet so the next register write lands between packets
        while (gen_phase != WAIT_FLAGS)
            queue_byte(BYTE_W'($urandom_range(255)));
    endtask

    // Sender: bursts of words with random gaps between them
    always @(posedge aclk) begin : drive_proc
        logic nxt_valid;
        logic [BYTE_W-1:0] nxt_byte;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_mouse_byte <= '0;
        end else begin
            if (s_valid && s_ready)
                track_byte(s_mouse_byte);
            nxt_valid = s_valid && !s_ready;
            nxt_byte = s_mouse_byte;
            if (!nxt_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_bytes.size() != 0) begin
                    nxt_byte = pending_bytes.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
            s_valid <= nxt_valid;
            s_mouse_byte <= nxt_byte;
        end
    end

    // Receiver: short stalls between ready stretches, and one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (m_ready && $urandom_range(1) == 1) begin
            m_ready <= 1'b0;
            rx_left <= $urandom_range(0, 5);
        end else begin
            m_ready <= 1'b1;
            rx_left <= $urandom_range(0, 30);
        end
    end

    always @(posedge aclk) begin : check_proc
        cursor_t due;
        if (aresetn && m_valid && m_ready) begin
            if (cursor_due.size() == 0) begin
                $error("unexpected cursor word: x %0d y %0d buttons %0d clickable %0d",
                       m_cursor_x, m_cursor_y, m_button_bits, m_clickable);
                mismatch_count++;
            end else begin
                due = cursor_due.pop_front();
                if (m_cursor_x !== due.cursor_x) begin
                    $error("cursor_x: expected %0d, got %0d", due.cursor_x, m_cursor_x);
                    mismatch_count++;
                end
                if (m_cursor_y !== due.cursor_y) begin
                    $error("cursor_y: expected %0d, got %0d", due.cursor_y, m_cursor_y);
                    mismatch_count++;
                end
                if (m_button_bits !== due.button_bits) begin
                    $error("button_bits: expected %0d, got %0d", due.button_bits, m_button_bits);
                    mismatch_count++;
                end
                if (m_clickable !== due.clickable) begin
                    $error("clickable: expected %0d, got %0d", due.clickable, m_clickable);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: loose bytes, extreme moves, all buttons, both signs, overflow drops
        queue_byte(8'h00);
        queue_byte(8'hF7);
        queue_packet(8'h08, 8'h00, 8'h00);
        queue_packet(8'h0F, 8'h7F, 8'h80);
        queue_packet(8'h38, 8'h80, 8'h7F);
        queue_packet(8'h39, 8'h00, 8'h00);
        queue_packet(8'h48, 8'h55, 8'h55);
        queue_packet(8'hFF, 8'hFF, 8'hFF);
        queue_packet(8'h0A, 8'hFF, 8'hFF);

        run_setting(WIDTH_RESET, HEIGHT_RESET, 110, 1'b0);
        run_setting(13'd1, 13'd1, 60, 1'b0);
        run_setting(EXT_FULL, EXT_FULL, 130, 1'b1);
        run_setting(13'd0, 13'd0, 50, 1'b0);
        run_setting(13'd8191, 13'd4097, 130, 1'b0);
        run_setting(EXT_W'($urandom_range(1, 4096)), EXT_W'($urandom_range(1, 4096)), 130, 1'b0);
        run_setting(13'd17, EXT_FULL, 110, 1'b0);
        run_setting(EXT_FULL, 13'd1, 100, 1'b0);

        wait_idle();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
